// File: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; no dependencies.
package spq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned COUNT_W        = 5;

  // Operation codes; the spare code behaves as a query
  typedef enum logic [1:0] {
    MODE_QUERY   = 2'd0,
    MODE_ENQUEUE = 2'd1,
    MODE_DEQUEUE = 2'd2,
    MODE_SPARE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    ORDER_LARGEST  = 1'b0,
    ORDER_SMALLEST = 1'b1
  } order_t;

  typedef struct packed {
    logic [1:0]                mode;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] popped_value;
    logic signed [VALUE_W-1:0] head_value;
    logic signed [VALUE_W-1:0] tail_value;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_empty;
    logic                      is_full;
    logic [1:0]                status;
  } out_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic   enq;
    logic   deq;
    order_t order;
  } cell_ctl_t;

endpackage

// File: rtl/spq_cell.sv
// One storage cell of the sorted priority queue.
// Depends on spq_pkg; instantiated in a row by sorted_priority_queue.
module spq_cell #(
  parameter int unsigned DW = spq_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  spq_pkg::cell_ctl_t    ctl,
  input  logic signed [DW-1:0]  ins_val,
  input  logic signed [DW-1:0]  prev_val,
  input  logic signed [DW-1:0]  next_val,
  input  logic                  occ,
  input  logic                  found_in,
  output logic                  found_out,
  output logic signed [DW-1:0]  val
);

  logic signed [DW-1:0] val_r;
  logic signed [DW-1:0] val_nxt;
  logic                 better;
  logic                 stop;

  // stored value strictly ahead of the incoming one?
  assign better = (ctl.order == spq_pkg::ORDER_SMALLEST) ? (val_r < ins_val)
                                                         : (val_r > ins_val);
  assign stop      = !occ || !better;
  assign found_out = found_in || stop;

  // enqueue and dequeue never come together; with neither, the cell holds
  always_comb begin
    val_nxt = val_r;
    if (ctl.enq) begin
      if (found_in)  val_nxt = prev_val;
      else if (stop) val_nxt = ins_val;
    end else if (ctl.deq) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// File: rtl/sorted_priority_queue.sv
// Sorted priority queue top level: a row of spq_cell instances plus count
// and result registers. Depends on spq_pkg and spq_cell.
//
// Usage:
//   Input: an item (mode, value) is transferred on a rising edge with start
//   high and busy low. busy stays low: one item may be given every cycle.
//   Result: exactly one per item, on out_data with out_valid high for one
//   cycle, the cycle after the item's transfer. The receiver
//   cannot stall; results are never held back.
//   Throughput: one item per cycle. The insert position is found by a
//   ripple of found flags through the row of cells, so the path through
//   DEPTH compare-and-OR stages sets the clock rate.
//   Configuration: cfg_data[0] selects the order (0 largest first,
//   1 smallest first); cfg_ready is always high. Write only while idle.
//   Stored values are not re-sorted when the order changes.
//   Reset (rst_n low, synchronous): count and order cleared, no result
//   pending. Entry contents are not cleared; only entries below the count
//   are ever shown.
//   Enqueue into a full queue is dropped (status overflow); dequeue from an
//   empty queue returns 0 (status underflow).
module sorted_priority_queue #(
  parameter int unsigned DEPTH      = spq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  spq_pkg::in_t   in_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [0:0]     cfg_data,
  output logic           out_valid,
  output spq_pkg::out_t  out_data
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = spq_pkg::VALUE_W;

  spq_pkg::order_t           order_r;
  logic [CW-1:0]             cnt_r;
  logic [CW-1:0]             cnt_nxt;
  logic                      out_valid_r;
  logic signed [VW-1:0]      popped_r;
  logic [1:0]                status_r;
  logic signed [VW-1:0]      popped_nxt;
  spq_pkg::status_t          status_nxt;

  logic                      accept;
  logic                      is_enq;
  logic                      is_deq;
  logic                      full;
  logic                      empty;
  spq_pkg::cell_ctl_t        ctl;
  logic signed [DATA_WIDTH-1:0] ins_val;
  logic signed [63:0]        in_ext;
  logic signed [DATA_WIDTH-1:0] cell_val [DEPTH];
  logic                      found     [DEPTH+1];
  logic signed [DATA_WIDTH-1:0] tail_raw;
  logic [CW-1:0]             tail_idx;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign full   = (cnt_r == CW'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign is_enq = (in_data.mode == spq_pkg::MODE_ENQUEUE);
  assign is_deq = (in_data.mode == spq_pkg::MODE_DEQUEUE);

  assign ctl.enq   = accept && is_enq && !full;
  assign ctl.deq   = accept && is_deq && !empty;
  assign ctl.order = order_r;

  // input sign-extended then cut to the storage width
  assign in_ext  = 64'(in_data.value);
  assign ins_val = in_ext[DATA_WIDTH-1:0];

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] prev_v;
    logic signed [DATA_WIDTH-1:0] next_v;
    if (i == 0) begin : g_first
      assign prev_v = ins_val;
    end else begin : g_mid
      assign prev_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_v = cell_val[i];
    end else begin : g_inner
      assign next_v = cell_val[i+1];
    end

    spq_cell #(.DW(DATA_WIDTH)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .ins_val   (ins_val),
      .prev_val  (prev_v),
      .next_val  (next_v),
      .occ       (CW'(i) < cnt_r),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .val       (cell_val[i])
    );
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    popped_nxt = '0;
    status_nxt = spq_pkg::STATUS_OK;
    if (accept) begin
      if (is_enq) begin
        if (full) status_nxt = spq_pkg::STATUS_OVERFLOW;
        else      cnt_nxt    = cnt_r + CW'(1);
      end else if (is_deq) begin
        if (empty) begin
          status_nxt = spq_pkg::STATUS_UNDERFLOW;
        end else begin
          cnt_nxt    = cnt_r - CW'(1);
          popped_nxt = VW'(64'(cell_val[0]));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r     <= spq_pkg::ORDER_LARGEST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) order_r <= spq_pkg::order_t'(cfg_data[0]);
      cnt_r       <= cnt_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
    end
  end

  // tail select: one-hot OR over the row
  assign tail_idx = cnt_r - CW'(1);
  always_comb begin
    tail_raw = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CW'(i) == tail_idx) tail_raw = tail_raw | cell_val[i];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_data.popped_value = popped_r;
  assign out_data.head_value   = empty ? '0 : VW'(64'(cell_val[0]));
  assign out_data.tail_value   = empty ? '0 : VW'(64'(tail_raw));
  assign out_data.entry_count  = spq_pkg::COUNT_W'(cnt_r);
  assign out_data.is_empty     = empty;
  assign out_data.is_full      = full;
  assign out_data.status       = status_r;

endmodule

// File: test/sorted_priority_queue_tb.sv
// Self-checking testbench for sorted_priority_queue: a queued driver and a result monitor,
// with a predictor that holds its own sorted array. Depends on spq_pkg and the RTL.
module sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Q_DEPTH = spq_pkg::DEPTH_DEF;

  typedef logic signed [spq_pkg::VALUE_W-1:0] val_t;

  typedef enum {ACT_ITEM, ACT_SETTLE, ACT_ORDER} act_kind_t;

  typedef struct {
    act_kind_t        kind;
    spq_pkg::in_t     item;
    int               gap_pct;
    spq_pkg::order_t  order;
  } backlog_op_t;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  spq_pkg::in_t   in_data;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [0:0]     cfg_data;
  logic           out_valid;
  spq_pkg::out_t  out_data;

  sorted_priority_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  backlog_op_t     op_backlog[$];
  spq_pkg::out_t   queue_views[$];
  int              bad_count = 0;
  bit              item_took = 0;
  bit              cfg_took  = 0;

  // Predicted queue contents
  val_t            held [Q_DEPTH];
  int              held_count = 0;
  spq_pkg::order_t held_order = spq_pkg::ORDER_LARGEST;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL sorted_priority_queue");
    $finish;
  end

  function automatic bit outranks(val_t a, val_t b);
    return (held_order == spq_pkg::ORDER_SMALLEST) ? (a < b) : (a > b);
  endfunction

  function automatic spq_pkg::out_t apply_queue_op(spq_pkg::in_t op);
    spq_pkg::out_t r;
    int            pos;
    r = '0;
    case (op.mode)
      spq_pkg::MODE_ENQUEUE: begin
        if (held_count >= Q_DEPTH) begin
          r.status = spq_pkg::STATUS_OVERFLOW;
        end else begin
          // new value goes ahead of the first entry it does not lose to
          pos = 0;
          while (pos < held_count && outranks(held[pos], op.value)) pos++;
          for (int i = held_count; i > pos; i--) held[i] = held[i-1];
          held[pos] = op.value;
          held_count++;
        end
      end
      spq_pkg::MODE_DEQUEUE: begin
        if (held_count == 0) begin
          r.status = spq_pkg::STATUS_UNDERFLOW;
        end else begin
          r.popped_value = held[0];
          for (int i = 0; i < held_count - 1; i++) held[i] = held[i+1];
          held_count--;
        end
      end
      default: ;
    endcase
    if (held_count > 0) begin
      r.head_value = held[0];
      r.tail_value = held[held_count-1];
    end
    r.entry_count = spq_pkg::COUNT_W'(held_count);
    r.is_empty    = (held_count == 0);
    r.is_full     = (held_count >= Q_DEPTH);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      bad_count++;
      if (bad_count <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  // Result monitor and transfer tracking
  always @(posedge clk) begin : watch
    spq_pkg::out_t want;
    if (!rst_n) begin
      item_took = 0;
      cfg_took  = 0;
    end else begin
      if (out_valid) begin
        if (queue_views.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) $display("%0t: result with none expected", $realtime);
        end else begin
          want = queue_views.pop_front();
          check_field("popped_value", want.popped_value, out_data.popped_value);
          check_field("head_value", want.head_value, out_data.head_value);
          check_field("tail_value", want.tail_value, out_data.tail_value);
          check_field("entry_count", 32'(want.entry_count), 32'(out_data.entry_count));
          check_field("is_empty", 32'(want.is_empty), 32'(out_data.is_empty));
          check_field("is_full", 32'(want.is_full), 32'(out_data.is_full));
          check_field("status", 32'(want.status), 32'(out_data.status));
        end
      end
      item_took = start && !busy;
      cfg_took  = cfg_valid && cfg_ready;
      if (item_took) queue_views.push_back(apply_queue_op(in_data));
      if (cfg_took) held_order = spq_pkg::order_t'(cfg_data[0]);
    end
  end

  // Driver: one decision per falling edge, one assignment per signal
  always @(negedge clk) begin : drive
    logic          nx_start;
    logic          nx_cfg_valid;
    spq_pkg::in_t  nx_item;
    logic [0:0]    nx_cfg;
    backlog_op_t   act;
    nx_start     = start;
    nx_cfg_valid = cfg_valid;
    nx_item      = in_data;
    nx_cfg       = cfg_data;
    if (rst_n !== 1'b1) begin
      nx_start     = 1'b0;
      nx_cfg_valid = 1'b0;
    end else begin
      if (start && item_took) nx_start = 1'b0;
      if (cfg_valid && cfg_took) nx_cfg_valid = 1'b0;
      if (!nx_start && !nx_cfg_valid && op_backlog.size() > 0) begin
        act = op_backlog[0];
        case (act.kind)
          ACT_ITEM: begin
            if ($urandom_range(99) >= act.gap_pct) begin
              nx_start = 1'b1;
              nx_item  = act.item;
              void'(op_backlog.pop_front());
            end
          end
          ACT_SETTLE: begin
            if (queue_views.size() == 0) void'(op_backlog.pop_front());
          end
          ACT_ORDER: begin
            if (queue_views.size() == 0) begin
              nx_cfg_valid = 1'b1;
              nx_cfg       = act.order;
              void'(op_backlog.pop_front());
            end
          end
          default: ;
        endcase
      end
    end
    start     <= nx_start;
    cfg_valid <= nx_cfg_valid;
    in_data   <= nx_item;
    cfg_data  <= nx_cfg;
  end

  task automatic push_item(spq_pkg::mode_t mode, val_t value, int gap_pct);
    backlog_op_t a;
    a.kind       = ACT_ITEM;
    a.item.mode  = mode;
    a.item.value = value;
    a.gap_pct    = gap_pct;
    a.order      = spq_pkg::ORDER_LARGEST;
    op_backlog.push_back(a);
  endtask

  task automatic push_settle();
    backlog_op_t a;
    a.kind    = ACT_SETTLE;
    a.item    = '0;
    a.gap_pct = 0;
    a.order   = spq_pkg::ORDER_LARGEST;
    op_backlog.push_back(a);
  endtask

  // Order writes only go out once the queue of expected results is empty
  task automatic push_order(spq_pkg::order_t order);
    backlog_op_t a;
    push_settle();
    a.kind    = ACT_ORDER;
    a.item    = '0;
    a.gap_pct = 0;
    a.order   = order;
    op_backlog.push_back(a);
  endtask

  function automatic val_t pick_value();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return $urandom_range(1) ? 32'sd0 : -32'sd1;
      3, 4, 5: return int'($urandom_range(15)) - 8;  // narrow range, plenty of ties
      default: return $urandom;
    endcase
  endfunction

  function automatic spq_pkg::mode_t pick_mode(int fill_pct);
    int sel;
    sel = $urandom_range(99);
    if (sel < 4) return spq_pkg::MODE_QUERY;
    if (sel < 8) return spq_pkg::MODE_SPARE;
    return ($urandom_range(99) < fill_pct) ? spq_pkg::MODE_ENQUEUE : spq_pkg::MODE_DEQUEUE;
  endfunction

  initial begin : stimulus
    int gaps [4];
    int fills [3];
    int n;
    int burst;
    int fill_pct;
    gaps  = '{0, 86, 0, 23};
    fills = '{80, 25, 55};
    rst_n     = 1'b0;
    start     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_data   = '0;

    // Directed: empty-queue cases, extremes, ties, filling past full
    push_order(spq_pkg::ORDER_LARGEST);
    push_item(spq_pkg::MODE_QUERY, 32'sd0, 0);
    push_item(spq_pkg::MODE_DEQUEUE, 32'sd77, 0);
    push_item(spq_pkg::MODE_SPARE, -32'sd5, 0);
    push_item(spq_pkg::MODE_ENQUEUE, 32'sh7fffffff, 0);
    push_item(spq_pkg::MODE_ENQUEUE, 32'sh80000000, 0);
    push_item(spq_pkg::MODE_ENQUEUE, 32'sd0, 0);
    push_item(spq_pkg::MODE_ENQUEUE, -32'sd1, 0);
    push_item(spq_pkg::MODE_ENQUEUE, 32'sd1, 0);
    push_item(spq_pkg::MODE_ENQUEUE, 32'sd0, 0);
    for (int i = 0; i < 10; i++) push_item(spq_pkg::MODE_ENQUEUE, pick_value(), 0);
    push_item(spq_pkg::MODE_ENQUEUE, 32'sd42, 0);
    push_item(spq_pkg::MODE_QUERY, 32'sd0, 0);
    push_item(spq_pkg::MODE_DEQUEUE, 32'sd0, 0);
    push_item(spq_pkg::MODE_DEQUEUE, 32'sd0, 0);
    // flip the order with values stored: no re-sort, later inserts use the new rule
    push_order(spq_pkg::ORDER_SMALLEST);
    push_item(spq_pkg::MODE_ENQUEUE, -32'sd3, 0);
    push_item(spq_pkg::MODE_DEQUEUE, 32'sd0, 0);

    for (int p = 0; p < 4; p++) begin
      push_order((p % 2) ? spq_pkg::ORDER_LARGEST : spq_pkg::ORDER_SMALLEST);
      n = 0;
      while (n < 235) begin
        burst    = $urandom_range(15, 40);
        fill_pct = fills[$urandom_range(2)];
        for (int k = 0; k < burst && n < 235; k++) begin
          push_item(pick_mode(fill_pct), pick_value(), gaps[p]);
          n++;
          if (n == 118) push_order(spq_pkg::order_t'($urandom_range(1)));
          else if (n == 60) push_settle();
        end
      end
    end

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (op_backlog.size() > 0 || start || cfg_valid || queue_views.size() > 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
    if (bad_count == 0)
      $display("PASS sorted_priority_queue");
    else
      $display("FAIL sorted_priority_queue");
    $finish;
  end

endmodule

// File: files.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
test/sorted_priority_queue_tb.sv
